// File: hw/rtl/ssnr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ssnr_pkg;

  localparam int FRAME_LEN_DEF      = 128;
  localparam int BLOCK_SAMPLES_DEF  = 32;
  localparam int OVERLAP_FRAMES_DEF = 4;

  localparam int THR_W = 49;
  localparam logic [THR_W-1:0] THR_RESET = 49'h1_0000_0000_0000;

  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [16:0] ALPHA_Q16 = 17'd62943;
  localparam logic [16:0] BETA_Q16  = 17'd26072;
  localparam logic [17:0] ATT_Q16   = 18'd107027;

  function automatic logic signed [63:0] round_sh(input logic signed [63:0] v,
                                                  input int unsigned s);
    logic [63:0] h;
    logic [63:0] m;
    logic [63:0] q;
    h = 64'd1 << (s - 1);
    if (v < 0) begin
      m = 64'(-v);
      q = (m + h) >> s;
      round_sh = -$signed(q);
    end else begin
      m = 64'(v);
      q = (m + h) >> s;
      round_sh = $signed(q);
    end
  endfunction

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (v < -36'sd2147483647) begin
      sat32 = 32'h8000_0001;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/spectral_subtraction_noise_reducer.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one sample per cycle while a block fills; after each BLOCK_SAMPLES-th
// sample the block stops taking input and runs the windowed load of N = FRAME_LEN
// samples, a bit-reversal pass (S swaps, 56 for N = 128), the forward FFT, the
// gain pass, a second bit-reversal pass, the inverse FFT and the frame write, then
// sends BLOCK_SAMPLES overlap-added results, each held until m_axis_tready.
// Reset: synchronous; a clearing pass zeroes the ring and frame stores before input is taken.
module spectral_subtraction_noise_reducer #(
  parameter int FRAME_LEN      = ssnr_pkg::FRAME_LEN_DEF,
  parameter int BLOCK_SAMPLES  = ssnr_pkg::BLOCK_SAMPLES_DEF,
  parameter int OVERLAP_FRAMES = ssnr_pkg::OVERLAP_FRAMES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] audio_in
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,  // [15:0] audio_out
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [48:0] cfg_data
);

  localparam int LN     = $clog2(FRAME_LEN);
  localparam int SW     = $clog2(OVERLAP_FRAMES);
  localparam int FAW    = LN + SW;
  localparam int FDEPTH = OVERLAP_FRAMES * FRAME_LEN;
  localparam int BW     = $clog2(BLOCK_SAMPLES);
  localparam int HOP    = FRAME_LEN / OVERLAP_FRAMES;
  localparam int IW     = $clog2(BLOCK_SAMPLES + FRAME_LEN) + 1;
  localparam int SLW    = $clog2(LN);
  localparam int SUMW   = 24 + SW + 1;
  localparam int VW     = SUMW + 18;
  localparam int XW     = SUMW + 1;
  localparam int QW     = XW + 32;
  localparam longint unsigned RCP = (64'd1 << 32) / OVERLAP_FRAMES;

  localparam logic [5:0] ST_CLEAR  = 6'd0;
  localparam logic [5:0] ST_IDLE   = 6'd1;
  localparam logic [5:0] ST_LD_RD  = 6'd2;
  localparam logic [5:0] ST_LD_MUL = 6'd3;
  localparam logic [5:0] ST_LD_WR  = 6'd4;
  localparam logic [5:0] ST_SW_RA  = 6'd5;
  localparam logic [5:0] ST_SW_RB  = 6'd6;
  localparam logic [5:0] ST_SW_WA  = 6'd7;
  localparam logic [5:0] ST_SW_WB  = 6'd8;
  localparam logic [5:0] ST_BF_RA  = 6'd9;
  localparam logic [5:0] ST_BF_RB  = 6'd10;
  localparam logic [5:0] ST_BF_MUL = 6'd11;
  localparam logic [5:0] ST_BF_ADD = 6'd12;
  localparam logic [5:0] ST_BF_WA  = 6'd13;
  localparam logic [5:0] ST_BF_WB  = 6'd14;
  localparam logic [5:0] ST_G_RD   = 6'd15;
  localparam logic [5:0] ST_G_AMP  = 6'd16;
  localparam logic [5:0] ST_G_SUM  = 6'd17;
  localparam logic [5:0] ST_G_THR  = 6'd18;
  localparam logic [5:0] ST_G_G    = 6'd19;
  localparam logic [5:0] ST_G_MUL  = 6'd20;
  localparam logic [5:0] ST_G_WR   = 6'd21;
  localparam logic [5:0] ST_FR_RD  = 6'd22;
  localparam logic [5:0] ST_FR_WR  = 6'd23;
  localparam logic [5:0] ST_O_RD   = 6'd24;
  localparam logic [5:0] ST_O_ACC  = 6'd25;
  localparam logic [5:0] ST_O_MUL  = 6'd26;
  localparam logic [5:0] ST_O_ABS  = 6'd27;
  localparam logic [5:0] ST_O_RCP  = 6'd28;
  localparam logic [5:0] ST_O_FIX  = 6'd29;
  localparam logic [5:0] ST_O_SEND = 6'd30;

  logic [5:0]       state;
  logic [FAW-1:0]   clr_cnt;
  logic [LN-1:0]    wptr;
  logic [BW-1:0]    fill;
  logic [LN-1:0]    cnt;
  logic [LN-2:0]    bj;
  logic [SLW-1:0]   stage;
  logic             inv;
  logic [48:0]      thr;
  logic [SW-1:0]    fslot;
  logic [SW-1:0]    o_slot;
  logic [SW-1:0]    o_f;
  logic [BW-1:0]    o_i;
  logic             o_vld;
  logic signed [SUMW-1:0] sum;

  logic signed [47:0] ld_prod;
  logic [63:0]        t_word;
  logic signed [31:0] ar, ai;
  logic signed [63:0] p1, p2, p3, p4;
  logic signed [33:0] tr, tv;
  logic [48:0]        pa;
  logic [48:0]        pb;
  logic signed [31:0] g_re, g_im;
  logic [31:0]        amp;
  logic [56:0]        ph;
  logic [55:0]        pl;
  logic [30:0]        gain;
  logic signed [63:0] mre, mim;
  logic signed [VW-1:0] o_v;
  logic               o_neg;
  logic [XW-1:0]      o_x;
  logic [QW-1:0]      o_qr;
  logic [15:0]        out_data;

  logic             in_xfer;
  logic [LN-1:0]    rev;
  logic [LN-1:0]    half_m;
  logic [LN-1:0]    k_idx;
  logic [LN-1:0]    a_idx;
  logic [LN-1:0]    b_idx;
  logic [LN-2:0]    ti;
  logic             sw_last;
  logic [IW-1:0]    o_idx;

  logic             ring_we;
  logic [LN-1:0]    ring_waddr;
  logic [15:0]      ring_wdata;
  logic [15:0]      ring_rdata;
  logic             sp_we;
  logic [LN-1:0]    sp_waddr;
  logic [LN-1:0]    sp_raddr;
  logic [63:0]      sp_wdata;
  logic [63:0]      sp_rdata;
  logic             fr_we;
  logic [FAW-1:0]   fr_waddr;
  logic [FAW-1:0]   fr_raddr;
  logic [23:0]      fr_wdata;
  logic [23:0]      fr_rdata;

  logic [30:0]        win;
  logic signed [31:0] tw_cos, tw_sin;
  logic signed [31:0] wi;
  logic signed [63:0] fr_round;
  logic [23:0]        fr_val;
  logic [57:0]        gsum;
  logic [XW+3:0]      rem;
  logic [XW-1:0]      q0;
  logic [XW-1:0]      qf;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = (state == ST_O_SEND);
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = m_axis_tvalid && (o_i == BW'(BLOCK_SAMPLES - 1));

  always_comb begin
    for (int b = 0; b < LN; b++) begin
      rev[b] = cnt[LN-1-b];
    end
  end

  assign sw_last = (cnt == LN'(FRAME_LEN - 1));
  assign half_m  = LN'(1) << stage;
  assign k_idx   = {1'b0, bj} & (half_m - LN'(1));
  assign a_idx   = LN'((({1'b0, bj} >> stage) << (32'(stage) + 32'd1))) | k_idx;
  assign b_idx   = a_idx | half_m;
  assign ti      = (LN-1)'(k_idx << (LN - 1 - 32'(stage)));
  assign wi      = inv ? -tw_sin : tw_sin;
  assign o_idx   = IW'(o_i) + (IW'(OVERLAP_FRAMES - 1) - IW'(o_f)) * IW'(HOP);

  assign fr_round = ssnr_pkg::round_sh(64'(signed'(sp_rdata[31:0])), LN);
  assign fr_val   = (fr_round > 64'sd8388607)  ? 24'h7F_FFFF :
                    (fr_round < -64'sd8388608) ? 24'h80_0000 : fr_round[23:0];
  assign gsum     = (58'(ph) + 58'(pl >> 24)) >> 10;
  assign q0       = XW'(o_qr >> 32);
  assign rem      = (XW+4)'(o_x) - (XW+4)'(q0) * (XW+4)'(OVERLAP_FRAMES);
  assign qf       = (rem >= (XW+4)'(OVERLAP_FRAMES)) ? q0 + XW'(1) : q0;

  ssnr_rom #(.FRAME_LEN(FRAME_LEN)) u_rom (
    .win_idx (cnt),
    .tw_idx  (ti),
    .win     (win),
    .tw_cos  (tw_cos),
    .tw_sin  (tw_sin)
  );

  always_comb begin
    ring_we    = 1'b0;
    ring_waddr = wptr;
    ring_wdata = s_axis_tdata;
    if (state == ST_CLEAR) begin
      ring_we    = 1'b1;
      ring_waddr = clr_cnt[LN-1:0];
      ring_wdata = '0;
    end else if (in_xfer) begin
      ring_we = 1'b1;
    end
  end

  ssnr_ram #(.WIDTH(16), .DEPTH(FRAME_LEN)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (wptr + cnt),
    .rdata (ring_rdata)
  );

  always_comb begin
    sp_we    = 1'b0;
    sp_waddr = cnt;
    sp_raddr = cnt;
    sp_wdata = sp_rdata;
    case (state)
      ST_LD_WR: begin
        sp_we    = 1'b1;
        sp_wdata = {32'd0, 32'(ssnr_pkg::round_sh(64'(ld_prod), 29))};
      end
      ST_SW_RB: sp_raddr = rev;
      ST_SW_WA: sp_we = 1'b1;
      ST_SW_WB: begin
        sp_we    = 1'b1;
        sp_waddr = rev;
        sp_wdata = t_word;
      end
      ST_BF_RA: sp_raddr = a_idx;
      ST_BF_RB: sp_raddr = b_idx;
      ST_BF_WA: begin
        sp_we    = 1'b1;
        sp_waddr = a_idx;
        sp_wdata = {ssnr_pkg::sat32(36'(ai) + 36'(tv)), ssnr_pkg::sat32(36'(ar) + 36'(tr))};
      end
      ST_BF_WB: begin
        sp_we    = 1'b1;
        sp_waddr = b_idx;
        sp_wdata = {ssnr_pkg::sat32(36'(ai) - 36'(tv)), ssnr_pkg::sat32(36'(ar) - 36'(tr))};
      end
      ST_G_WR: begin
        sp_we    = 1'b1;
        sp_wdata = {32'(ssnr_pkg::round_sh(mim, 30)), 32'(ssnr_pkg::round_sh(mre, 30))};
      end
      default: ;
    endcase
  end

  ssnr_ram #(.WIDTH(64), .DEPTH(FRAME_LEN)) u_spec (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp_wdata),
    .raddr (sp_raddr),
    .rdata (sp_rdata)
  );

  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = {fslot, cnt};
    fr_wdata = fr_val;
    if (state == ST_CLEAR) begin
      fr_we    = 1'b1;
      fr_waddr = clr_cnt;
      fr_wdata = '0;
    end else if (state == ST_FR_WR) begin
      fr_we = 1'b1;
    end
  end

  assign fr_raddr = {o_slot, o_idx[LN-1:0]};

  ssnr_ram #(.WIDTH(24), .DEPTH(FDEPTH)) u_frames (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= ssnr_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_LD_MUL: ld_prod <= 48'(signed'(ring_rdata)) * 48'(signed'({1'b0, win}));
      ST_SW_RB:  t_word <= sp_rdata;
      ST_BF_RB: begin
        ar <= sp_rdata[31:0];
        ai <= sp_rdata[63:32];
      end
      ST_BF_MUL: begin
        p1 <= 64'(tw_cos) * 64'(signed'(sp_rdata[31:0]));
        p2 <= 64'(wi) * 64'(signed'(sp_rdata[63:32]));
        p3 <= 64'(tw_cos) * 64'(signed'(sp_rdata[63:32]));
        p4 <= 64'(wi) * 64'(signed'(sp_rdata[31:0]));
      end
      ST_BF_ADD: begin
        tr <= 34'(ssnr_pkg::round_sh(p1 - p2, 30));
        tv <= 34'(ssnr_pkg::round_sh(p3 + p4, 30));
      end
      ST_G_AMP: begin
        g_re <= sp_rdata[31:0];
        g_im <= sp_rdata[63:32];
        if (((sp_rdata[31]) ? 32'(-signed'(33'(signed'(sp_rdata[31:0]))))
                            : sp_rdata[31:0]) >
            ((sp_rdata[63]) ? 32'(-signed'(33'(signed'(sp_rdata[63:32]))))
                            : sp_rdata[63:32])) begin
          pa <= 49'(ssnr_pkg::ALPHA_Q16) *
                49'(sp_rdata[31] ? 32'(-signed'(33'(signed'(sp_rdata[31:0])))) : sp_rdata[31:0]);
          pb <= 49'(ssnr_pkg::BETA_Q16) *
                49'(sp_rdata[63] ? 32'(-signed'(33'(signed'(sp_rdata[63:32])))) : sp_rdata[63:32]);
        end else begin
          pa <= 49'(ssnr_pkg::ALPHA_Q16) *
                49'(sp_rdata[63] ? 32'(-signed'(33'(signed'(sp_rdata[63:32])))) : sp_rdata[63:32]);
          pb <= 49'(ssnr_pkg::BETA_Q16) *
                49'(sp_rdata[31] ? 32'(-signed'(33'(signed'(sp_rdata[31:0])))) : sp_rdata[31:0]);
        end
      end
      ST_G_SUM: amp <= 32'((50'(pa) + 50'(pb)) >> (LN + 16));
      ST_G_THR: begin
        ph <= 57'(amp) * 57'(thr[48:24]);
        pl <= 56'(amp) * 56'(thr[23:0]);
      end
      ST_G_G:   gain <= (gsum > 58'(ssnr_pkg::ONE_Q30)) ? ssnr_pkg::ONE_Q30 : 31'(gsum);
      ST_G_MUL: begin
        mre <= 64'(g_re) * 64'(signed'({1'b0, gain}));
        mim <= 64'(g_im) * 64'(signed'({1'b0, gain}));
      end
      ST_O_MUL: o_v <= VW'(sum) * VW'(signed'({1'b0, ssnr_pkg::ATT_Q16}));
      ST_O_ABS: begin
        o_neg <= o_v[VW-1];
        o_x   <= XW'(((o_v[VW-1] ? VW'(-o_v) : VW'(o_v)) +
                      VW'(OVERLAP_FRAMES) * VW'(65536)) >> 17);
      end
      ST_O_RCP: o_qr <= QW'(o_x) * QW'(RCP);
      ST_O_FIX: begin
        if (o_neg) begin
          out_data <= (qf > XW'(32768)) ? 16'h8000 : 16'(-qf);
        end else begin
          out_data <= (qf > XW'(32767)) ? 16'h7FFF : 16'(qf);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      wptr    <= '0;
      fill    <= '0;
      cnt     <= '0;
      bj      <= '0;
      stage   <= '0;
      inv     <= 1'b0;
      fslot   <= '0;
      o_slot  <= '0;
      o_f     <= '0;
      o_i     <= '0;
      o_vld   <= 1'b0;
      sum     <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + FAW'(1);
          if (clr_cnt == FAW'(FDEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            wptr <= wptr + LN'(1);
            if (fill == BW'(BLOCK_SAMPLES - 1)) begin
              fill  <= '0;
              cnt   <= '0;
              state <= ST_LD_RD;
            end else begin
              fill <= fill + BW'(1);
            end
          end
        end
        ST_LD_RD:  state <= ST_LD_MUL;
        ST_LD_MUL: state <= ST_LD_WR;
        ST_LD_WR: begin
          cnt <= cnt + LN'(1);
          if (sw_last) begin
            inv   <= 1'b0;
            state <= ST_SW_RA;
          end else begin
            state <= ST_LD_RD;
          end
        end
        ST_SW_RA, ST_SW_WB: begin
          if (state == ST_SW_RA && rev > cnt) begin
            state <= ST_SW_RB;
          end else begin
            cnt <= cnt + LN'(1);
            if (sw_last) begin
              bj    <= '0;
              stage <= '0;
              state <= ST_BF_RA;
            end else begin
              state <= ST_SW_RA;
            end
          end
        end
        ST_SW_RB:  state <= ST_SW_WA;
        ST_SW_WA:  state <= ST_SW_WB;
        ST_BF_RA:  state <= ST_BF_RB;
        ST_BF_RB:  state <= ST_BF_MUL;
        ST_BF_MUL: state <= ST_BF_ADD;
        ST_BF_ADD: state <= ST_BF_WA;
        ST_BF_WA:  state <= ST_BF_WB;
        ST_BF_WB: begin
          bj <= bj + (LN-1)'(1);
          if (bj == (LN-1)'(FRAME_LEN/2 - 1)) begin
            if (stage == SLW'(LN - 1)) begin
              cnt   <= '0;
              state <= inv ? ST_FR_RD : ST_G_RD;
            end else begin
              stage <= stage + SLW'(1);
              state <= ST_BF_RA;
            end
          end else begin
            state <= ST_BF_RA;
          end
        end
        ST_G_RD:  state <= ST_G_AMP;
        ST_G_AMP: state <= ST_G_SUM;
        ST_G_SUM: state <= ST_G_THR;
        ST_G_THR: state <= ST_G_G;
        ST_G_G:   state <= ST_G_MUL;
        ST_G_MUL: state <= ST_G_WR;
        ST_G_WR: begin
          cnt <= cnt + LN'(1);
          if (sw_last) begin
            inv   <= 1'b1;
            state <= ST_SW_RA;
          end else begin
            state <= ST_G_RD;
          end
        end
        ST_FR_RD: state <= ST_FR_WR;
        ST_FR_WR: begin
          cnt <= cnt + LN'(1);
          if (sw_last) begin
            fslot  <= (fslot == SW'(OVERLAP_FRAMES - 1)) ? '0 : fslot + SW'(1);
            o_slot <= (fslot == SW'(OVERLAP_FRAMES - 1)) ? '0 : fslot + SW'(1);
            o_f    <= '0;
            o_i    <= '0;
            sum    <= '0;
            state  <= ST_O_RD;
          end else begin
            state <= ST_FR_RD;
          end
        end
        ST_O_RD: begin
          o_vld <= (o_idx < IW'(FRAME_LEN));
          state <= ST_O_ACC;
        end
        ST_O_ACC: begin
          if (o_vld) begin
            sum <= sum + SUMW'(signed'(fr_rdata));
          end
          if (o_f == SW'(OVERLAP_FRAMES - 1)) begin
            state <= ST_O_MUL;
          end else begin
            o_f    <= o_f + SW'(1);
            o_slot <= (o_slot == SW'(OVERLAP_FRAMES - 1)) ? '0 : o_slot + SW'(1);
            state  <= ST_O_RD;
          end
        end
        ST_O_MUL: state <= ST_O_ABS;
        ST_O_ABS: state <= ST_O_RCP;
        ST_O_RCP: state <= ST_O_FIX;
        ST_O_FIX: state <= ST_O_SEND;
        ST_O_SEND: begin
          if (m_axis_tready) begin
            if (o_i == BW'(BLOCK_SAMPLES - 1)) begin
              state <= ST_IDLE;
            end else begin
              o_i    <= o_i + BW'(1);
              o_f    <= '0;
              o_slot <= fslot;
              sum    <= '0;
              state  <= ST_O_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_take_while_sending: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result is pending");

  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("block not idle after last result");

  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !s_axis_tready)
    else $error("input taken before clearing pass");

endmodule
`default_nettype wire

// File: hw/rtl/ssnr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ssnr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/ssnr_rom.sv
`timescale 1ns / 1ps
`default_nettype none
module ssnr_rom #(
  parameter int FRAME_LEN = ssnr_pkg::FRAME_LEN_DEF
) (
  input  wire logic [$clog2(FRAME_LEN)-1:0] win_idx,
  input  wire logic [$clog2(FRAME_LEN)-2:0] tw_idx,
  output logic      [30:0]                  win,
  output logic signed [31:0]                tw_cos,
  output logic signed [31:0]                tw_sin
);

  localparam longint unsigned D = FRAME_LEN;

  logic [30:0]        win_tab [FRAME_LEN];
  logic signed [31:0] cos_tab [FRAME_LEN/2];
  logic signed [31:0] sin_tab [FRAME_LEN/2];

  for (genvar n = 0; n < FRAME_LEN; n++) begin : g_win
    localparam longint unsigned M   = (longint'(n) + D/4) % D;
    localparam bit              NG  = M > D/2;
    localparam longint unsigned R   = NG ? D - M : M;
    localparam longint unsigned U   = 2*R;
    localparam longint unsigned NUM = 16*U*(D-U);
    localparam longint unsigned DEN = 5*D*D - 4*U*(D-U);
    localparam longint unsigned VAL = ((NUM << 30) + DEN/2) / DEN;
    localparam longint          SV  = NG ? -longint'(VAL) : longint'(VAL);
    localparam longint          T   = 64'sd1073741824 - SV;
    localparam longint          Q   = (T + 1) / 2;
    assign win_tab[n] = 31'(Q);
  end

  for (genvar n = 0; n < FRAME_LEN/2; n++) begin : g_tw
    localparam longint unsigned MS   = (D - longint'(n)) % D;
    localparam bit              SN   = MS > D/2;
    localparam longint unsigned SR   = SN ? D - MS : MS;
    localparam longint unsigned SU   = 2*SR;
    localparam longint unsigned SNUM = 16*SU*(D-SU);
    localparam longint unsigned SDEN = 5*D*D - 4*SU*(D-SU);
    localparam longint unsigned SVAL = ((SNUM << 30) + SDEN/2) / SDEN;
    localparam longint          SS   = SN ? -longint'(SVAL) : longint'(SVAL);
    localparam longint unsigned MC   = (MS + D/4) % D;
    localparam bit              CN   = MC > D/2;
    localparam longint unsigned CR   = CN ? D - MC : MC;
    localparam longint unsigned CU   = 2*CR;
    localparam longint unsigned CNUM = 16*CU*(D-CU);
    localparam longint unsigned CDEN = 5*D*D - 4*CU*(D-CU);
    localparam longint unsigned CVAL = ((CNUM << 30) + CDEN/2) / CDEN;
    localparam longint          CS   = CN ? -longint'(CVAL) : longint'(CVAL);
    assign sin_tab[n] = 32'(SS);
    assign cos_tab[n] = 32'(CS);
  end

  assign win    = win_tab[win_idx];
  assign tw_cos = cos_tab[tw_idx];
  assign tw_sin = sin_tab[tw_idx];

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  typedef struct {
    logic [15:0] audio;
    logic        last;
  } audio_result_t;

  class reduced_audio_board;
    shortint       ring[128];
    longint        frames[4][128];
    longint        spec_re[128];
    longint        spec_im[128];
    longint        hann[128];
    longint        tw_re[64];
    longint        tw_im[64];
    int            write_pos;
    int            fill;
    int            slot;
    logic [48:0]   thr;
    audio_result_t pending_audio[$];

    function new();
      for (int n = 0; n < 128; n++) begin
        ring[n] = 0;
        for (int f = 0; f < 4; f++) frames[f][n] = 0;
        hann[n] = (64'sd1073741824 - bhaskara((n + 32) % 128) + 1) / 2;
      end
      for (int n = 0; n < 64; n++) begin
        tw_im[n] = bhaskara((128 - n) % 128);
        tw_re[n] = bhaskara(((128 - n) % 128 + 32) % 128);
      end
      write_pos = 0;
      fill = 0;
      slot = 0;
      thr = ssnr_pkg::THR_RESET;
    endfunction

    function longint bhaskara(int m);
      longint unsigned r, u, num, den, val;
      logic neg;
      r = m % 128;
      neg = 0;
      if (r > 64) begin
        neg = 1;
        r = 128 - r;
      end
      u = 2 * r;
      num = 16 * u * (128 - u);
      den = 5 * 128 * 128 - 4 * u * (128 - u);
      val = ((num << 30) + den / 2) / den;
      return neg ? -longint'(val) : longint'(val);
    endfunction

    function longint rsh(longint v, int s);
      longint unsigned h, m;
      h = 64'd1 << (s - 1);
      if (v < 0) begin
        m = -v;
        return -longint'((m + h) >> s);
      end
      m = v;
      return longint'((m + h) >> s);
    endfunction

    function longint divr(longint v, longint d);
      longint unsigned m, ud;
      ud = d;
      if (v < 0) begin
        m = -v;
        return -longint'((m + ud / 2) / ud);
      end
      m = v;
      return longint'((m + ud / 2) / ud);
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void transform(logic inv);
      longint wr, wi, ar, ai, br, bi, tr, ti_v, t;
      int r, v, half, stp, a, b;
      for (int n = 0; n < 128; n++) begin
        r = 0;
        v = n;
        for (int k = 0; k < 7; k++) begin
          r = (r << 1) | (v & 1);
          v = v >> 1;
        end
        if (r > n) begin
          t = spec_re[n]; spec_re[n] = spec_re[r]; spec_re[r] = t;
          t = spec_im[n]; spec_im[n] = spec_im[r]; spec_im[r] = t;
        end
      end
      for (int size = 2; size <= 128; size = size << 1) begin
        half = size >> 1;
        stp = 128 / size;
        for (int g = 0; g < 128; g += size) begin
          for (int k = 0; k < half; k++) begin
            a = g + k;
            b = a + half;
            wr = tw_re[k * stp];
            wi = inv ? -tw_im[k * stp] : tw_im[k * stp];
            br = spec_re[b]; bi = spec_im[b];
            ar = spec_re[a]; ai = spec_im[a];
            tr = rsh(wr * br - wi * bi, 30);
            ti_v = rsh(wr * bi + wi * br, 30);
            spec_re[a] = clip(ar + tr, -2147483647, 2147483647);
            spec_im[a] = clip(ai + ti_v, -2147483647, 2147483647);
            spec_re[b] = clip(ar - tr, -2147483647, 2147483647);
            spec_im[b] = clip(ai - ti_v, -2147483647, 2147483647);
          end
        end
      end
    endfunction

    function void take_sample(logic signed [15:0] x);
      longint unsigned xr, xi, hi, lo, amp, ph, pl, g, thr_u;
      longint sum, v;
      audio_result_t res;
      ring[write_pos] = x;
      write_pos = (write_pos + 1) % 128;
      fill++;
      if (fill < 32) return;
      fill = 0;
      for (int i = 0; i < 128; i++) begin
        spec_re[i] = rsh(longint'(ring[(write_pos + i) % 128]) * hann[i], 29);
        spec_im[i] = 0;
      end
      transform(0);
      thr_u = thr;
      for (int i = 0; i < 128; i++) begin
        xr = spec_re[i] < 0 ? -spec_re[i] : spec_re[i];
        xi = spec_im[i] < 0 ? -spec_im[i] : spec_im[i];
        hi = xr > xi ? xr : xi;
        lo = xr > xi ? xi : xr;
        amp = ((62943 * hi + 26072 * lo) / 128) >> 16;
        ph = amp * (thr_u >> 24);
        pl = amp * (thr_u & 64'hFF_FFFF);
        g = (ph + (pl >> 24)) >> 10;
        if (g > 64'd1073741824) g = 64'd1073741824;
        spec_re[i] = rsh(spec_re[i] * longint'(g), 30);
        spec_im[i] = rsh(spec_im[i] * longint'(g), 30);
      end
      transform(1);
      for (int i = 0; i < 128; i++)
        frames[slot][i] = clip(divr(spec_re[i], 128), -8388608, 8388607);
      slot = (slot + 1) % 4;
      for (int i = 0; i < 32; i++) begin
        sum = 0;
        for (int f = 0; f < 4; f++) sum += frames[(slot + f) % 4][i + (3 - f) * 32];
        v = clip(divr(sum * 107027, 64'sd4 << 17), -32768, 32767);
        res.audio = v[15:0];
        res.last = (i == 31);
        pending_audio.push_back(res);
      end
    endfunction

    function string match_output(logic [15:0] audio, logic last);
      audio_result_t want;
      if (pending_audio.size() == 0)
        return $sformatf("unexpected output audio=%h last=%b", audio, last);
      want = pending_audio.pop_front();
      if (audio !== want.audio)
        return $sformatf("audio_out %h, want %h", audio, want.audio);
      if (last !== want.last)
        return $sformatf("block_end %b, want %b", last, want.last);
      return "";
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [48:0] cfg_data = 0;

  int send_idle = 14;
  int recv_idle = 50;
  int mismatches = 0;
  reduced_audio_board board = new();

  spectral_subtraction_noise_reducer DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  task report(string msg);
    $display("ERROR t=%0t %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    string msg;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      msg = board.match_output(m_axis_tdata, m_axis_tlast);
      if (msg != "") report(msg);
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  task push_sample(logic [15:0] x);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= x;
    do @(posedge clk); while (!s_axis_tready);
    board.take_sample(x);
  endtask

  task load_threshold(logic [48:0] v);
    s_axis_tvalid <= 0;
    wait (board.pending_audio.size() == 0);
    repeat (100) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    board.thr = v;
  endtask

  task random_samples(int count);
    int kind, amp, period;
    logic [15:0] x;
    kind = 0;
    amp = 0;
    period = 1;
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) begin
        kind = $urandom_range(3);
        amp = $urandom_range(32767);
        period = $urandom_range(1, 9);
      end
      case (kind)
        0: x = 16'($urandom());
        1: x = 16'($signed($urandom_range(512)) - 256);
        2: x = ((i / period) % 2) ? 16'(amp) : 16'(-amp);
        default: x = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      endcase
      push_sample(x);
    end
  endtask

  logic [15:0] directed[24] = '{
    16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 16'h7FFF,
    16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
    16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000
  };
  logic [48:0] thresholds[6];

  initial begin
    thresholds[0] = ssnr_pkg::THR_RESET;
    thresholds[1] = 49'd0;
    thresholds[2] = {49{1'b1}};
    thresholds[3] = 49'h100_0000_0000;
    thresholds[4] = 49'({$urandom(), $urandom()});
    thresholds[5] = ssnr_pkg::THR_RESET;
    repeat (2) @(posedge clk);
    rst <= 0;
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle = 50;
        recv_idle = 14;
      end else if (p == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (p > 0) load_threshold(thresholds[p]);
      if (p == 0)
        foreach (directed[i]) push_sample(directed[i]);
      random_samples(p == 0 ? 40 : 40);
    end
    s_axis_tvalid <= 0;
    wait (board.pending_audio.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("spectral_subtraction_noise_reducer: match");
    end else begin
      $display("spectral_subtraction_noise_reducer: mismatch");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("spectral_subtraction_noise_reducer: mismatch");
    $finish;
  end

endmodule
